>>> rtl/core/cfe_pkg.sv
// shared constants, codes and types of the convolution filter block
`default_nettype none

package cfe_pkg;

    // store depths
    localparam int MAX_TAPS    = 64;
    localparam int MAX_SAMPLES = 1024;

    // address widths of the two stores
    localparam int TAP_AW = $clog2(MAX_TAPS);
    localparam int SMP_AW = $clog2(MAX_SAMPLES);

    // field widths
    localparam int REQ_W      = 2;
    localparam int POS_W      = 10;
    localparam int DATA_W     = 16;
    localparam int PROD_W     = 2 * DATA_W;
    localparam int SUM_W      = 38;
    localparam int STATUS_W   = 2;
    localparam int TAP_CNT_W  = 7;
    localparam int SER_LEN_W  = 11;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 11;

    // stream payload widths, padded to whole bytes
    localparam int IN_TDATA_W  = ((POS_W + DATA_W + 7) / 8) * 8;
    localparam int OUT_TDATA_W = ((SUM_W + 7) / 8) * 8;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_TAP_COUNT     = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SERIES_LENGTH = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_CENTERED      = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_CIRCULAR_WRAP = 2'd3;

    // request kinds
    typedef enum logic [REQ_W-1:0] {
        REQ_WR_TAP    = 2'd0,
        REQ_WR_SAMPLE = 2'd1,
        REQ_QUERY     = 2'd2
    } t_req;

    // result status codes
    typedef enum logic [STATUS_W-1:0] {
        STAT_OK    = 2'd0,
        STAT_EDGE  = 2'd1,
        STAT_RANGE = 2'd2,
        STAT_TAPS  = 2'd3
    } t_status;

    // query sequencer states
    typedef enum logic [2:0] {
        S_IDLE,
        S_CHECK,
        S_RUN,
        S_DRAIN,
        S_FINISH
    } t_state;

    // control from the sequencer to the multiply-accumulate unit
    typedef struct packed {
        logic clear;
        logic valid;
    } t_mac_ctl;

endpackage

`default_nettype wire

>>> rtl/core/cfe_mac.sv
// multiply-accumulate unit: registered product, then accumulate
`default_nettype none

module cfe_mac (
    input  wire                                i_clk,
    input  wire                                i_rst_n,
    input  wire  cfe_pkg::t_mac_ctl            i_ctl,
    input  wire  signed [cfe_pkg::DATA_W-1:0]  i_tap,
    input  wire  signed [cfe_pkg::DATA_W-1:0]  i_sample,
    output logic signed [cfe_pkg::SUM_W-1:0]   o_acc,
    output logic                               o_busy
);

    logic signed [cfe_pkg::PROD_W-1:0] r_prod;
    logic                              r_prod_vld;
    logic signed [cfe_pkg::SUM_W-1:0]  r_acc;
    logic signed [cfe_pkg::SUM_W-1:0]  n_acc;

    always_comb begin
        n_acc = r_acc;
        if (i_ctl.clear) begin
            n_acc = '0;
        end else if (r_prod_vld) begin
            n_acc = r_acc + cfe_pkg::SUM_W'(r_prod);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prod_vld <= 1'b0;
        end else begin
            r_prod_vld <= i_ctl.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_prod <= i_tap * i_sample;
        r_acc  <= n_acc;
    end

    assign o_acc  = r_acc;
    assign o_busy = r_prod_vld;

endmodule

`default_nettype wire

>>> rtl/core/convolution_filter_edges.sv
// top level of the convolution filter with edge handling
`default_nettype none

// Convolution filter over a stored series of signed 16-bit samples with up to
// 64 signed Q2.14 coefficients. Coefficients and samples are written by index
// through the input stream (tuser selects the kind of request); a query for
// output index i returns the exact sum over j of coefficient j times sample
// (i + shift - j), shift being half the tap count when centered. Outside
// circular mode a window that leaves the series reports "not available"; in
// circular mode indices wrap around the series ends. Results carry 14 fraction
// bits and are never saturated; sum_value is zero whenever status is nonzero.
// Sequence: a query is taken and its window is checked, then each tap
// reads one coefficient/sample pair into the single multiply-accumulate
// unit, then the read, product and accumulate registers drain and the
// result is loaded. A query with a nonzero status goes from the check
// straight to loading the result. The input stalls while a query is in
// flight; a finished result waits in the output register without holding
// up the next request. Both stores come up undefined and need no clearing
// pass.

module convolution_filter_edges (
    input  wire                                   i_clk,
    input  wire                                   i_rst_n,

    // configuration write port
    input  wire                                   i_cfg_we,
    input  wire  [cfe_pkg::CFG_IDX_W-1:0]         i_cfg_addr,
    input  wire  [cfe_pkg::CFG_DATA_W-1:0]        i_cfg_wdata,

    // request stream
    input  wire                                   s_axis_tvalid,
    output logic                                  s_axis_tready,
    input  wire  [cfe_pkg::IN_TDATA_W-1:0]        s_axis_tdata,  // position, value, zero pad
    input  wire  [cfe_pkg::REQ_W-1:0]             s_axis_tuser,  // req_type

    // result stream
    output logic                                  m_axis_tvalid,
    input  wire                                   m_axis_tready,
    output logic [cfe_pkg::OUT_TDATA_W-1:0]       m_axis_tdata,  // sum_value, zero pad
    output logic [cfe_pkg::STATUS_W-1:0]          m_axis_tuser   // status
);

    // request fields
    logic                                 in_req;
    logic [cfe_pkg::REQ_W-1:0]            in_type;
    logic [cfe_pkg::POS_W-1:0]            in_pos;
    logic [cfe_pkg::DATA_W-1:0]           in_value;

    // configuration registers
    logic [cfe_pkg::TAP_CNT_W-1:0]        r_tap_count;
    logic [cfe_pkg::SER_LEN_W-1:0]        r_series_length;
    logic                                 r_centered;
    logic                                 r_circular;

    // stores
    logic [cfe_pkg::DATA_W-1:0]           tap_mem [cfe_pkg::MAX_TAPS];
    logic [cfe_pkg::DATA_W-1:0]           smp_mem [cfe_pkg::MAX_SAMPLES];
    logic signed [cfe_pkg::DATA_W-1:0]    r_tap_rd;
    logic signed [cfe_pkg::DATA_W-1:0]    r_smp_rd;
    logic                                 r_rd_vld;

    // sequencer
    cfe_pkg::t_state                      r_state;
    cfe_pkg::t_state                      n_state;
    logic [cfe_pkg::POS_W-1:0]            r_pos;
    logic [cfe_pkg::SER_LEN_W-1:0]        r_nx;
    logic [cfe_pkg::SMP_AW-1:0]           r_k;
    logic [cfe_pkg::TAP_AW-1:0]           r_j;
    logic [cfe_pkg::TAP_CNT_W-1:0]        r_left;
    cfe_pkg::t_status                     r_status;

    // window check, worked out in the check state
    logic [cfe_pkg::TAP_CNT_W-1:0]        nf;
    logic [cfe_pkg::TAP_CNT_W-1:0]        shift;
    logic [cfe_pkg::SER_LEN_W-1:0]        nx;
    logic [cfe_pkg::SER_LEN_W-1:0]        pos_sh;
    logic [cfe_pkg::SMP_AW-1:0]           k0;
    cfe_pkg::t_status                     chk_status;

    // result register
    logic                                 r_out_vld;
    logic [cfe_pkg::SUM_W-1:0]            r_out_sum;
    cfe_pkg::t_status                     r_out_status;
    logic                                 out_load;

    // datapath
    logic                                 issue;
    cfe_pkg::t_mac_ctl                    mac_ctl;
    logic signed [cfe_pkg::SUM_W-1:0]     mac_acc;
    logic                                 mac_busy;

    assign in_type  = s_axis_tuser;
    assign in_pos   = s_axis_tdata[cfe_pkg::POS_W-1:0];
    assign in_value = s_axis_tdata[cfe_pkg::POS_W +: cfe_pkg::DATA_W];
    assign in_req   = s_axis_tvalid && s_axis_tready;

    assign s_axis_tready = (r_state == cfe_pkg::S_IDLE);

    // ---------------------------------------------------------------
    // configuration
    // ---------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tap_count     <= cfe_pkg::TAP_CNT_W'(1);
            r_series_length <= cfe_pkg::SER_LEN_W'(1);
            r_centered      <= 1'b0;
            r_circular      <= 1'b0;
        end else if (i_cfg_we) begin
            case (i_cfg_addr)
                cfe_pkg::CFG_TAP_COUNT:     r_tap_count     <= i_cfg_wdata[cfe_pkg::TAP_CNT_W-1:0];
                cfe_pkg::CFG_SERIES_LENGTH: r_series_length <= i_cfg_wdata;
                cfe_pkg::CFG_CENTERED:      r_centered      <= i_cfg_wdata[0];
                cfe_pkg::CFG_CIRCULAR_WRAP: r_circular      <= i_cfg_wdata[0];
                default: begin
                end
            endcase
        end
    end

    // ---------------------------------------------------------------
    // stores: writes from requests, one read of each per cycle
    // ---------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (in_req && (in_type == cfe_pkg::REQ_WR_TAP)
            && (in_pos < cfe_pkg::POS_W'(cfe_pkg::MAX_TAPS))) begin
            tap_mem[in_pos[cfe_pkg::TAP_AW-1:0]] <= in_value;
        end
        r_tap_rd <= tap_mem[r_j];
    end

    always_ff @(posedge i_clk) begin
        // every 10-bit position fits the sample store
        if (in_req && (in_type == cfe_pkg::REQ_WR_SAMPLE)) begin
            smp_mem[in_pos[cfe_pkg::SMP_AW-1:0]] <= in_value;
        end
        r_smp_rd <= smp_mem[r_k];
    end

    // ---------------------------------------------------------------
    // window check
    // ---------------------------------------------------------------
    always_comb begin
        // tap count and series length saturate at the store depths
        nf = (r_tap_count > cfe_pkg::TAP_CNT_W'(cfe_pkg::MAX_TAPS))
             ? cfe_pkg::TAP_CNT_W'(cfe_pkg::MAX_TAPS) : r_tap_count;
        nx = (r_series_length > cfe_pkg::SER_LEN_W'(cfe_pkg::MAX_SAMPLES))
             ? cfe_pkg::SER_LEN_W'(cfe_pkg::MAX_SAMPLES) : r_series_length;
        shift  = r_centered ? (nf >> 1) : '0;
        pos_sh = cfe_pkg::SER_LEN_W'(r_pos) + cfe_pkg::SER_LEN_W'(shift);

        // newest sample of the window, wrapped once in circular mode
        if (r_circular && (pos_sh >= nx)) begin
            k0 = cfe_pkg::SMP_AW'(pos_sh - nx);
        end else begin
            k0 = pos_sh[cfe_pkg::SMP_AW-1:0];
        end

        if (cfe_pkg::SER_LEN_W'(r_pos) >= nx) begin
            chk_status = cfe_pkg::STAT_RANGE;
        end else if (r_circular) begin
            chk_status = (cfe_pkg::SER_LEN_W'(nf) > nx) ? cfe_pkg::STAT_TAPS
                                                         : cfe_pkg::STAT_OK;
        end else if (((cfe_pkg::SER_LEN_W + 1)'(pos_sh) + (cfe_pkg::SER_LEN_W + 1)'(1)
                      < (cfe_pkg::SER_LEN_W + 1)'(nf)) || (pos_sh >= nx)) begin
            // window runs off the start or the end of the series
            chk_status = cfe_pkg::STAT_EDGE;
        end else begin
            chk_status = cfe_pkg::STAT_OK;
        end
    end

    // ---------------------------------------------------------------
    // sequencer
    // ---------------------------------------------------------------
    assign issue    = (r_state == cfe_pkg::S_RUN) && (r_left != '0);
    assign out_load = (r_state == cfe_pkg::S_FINISH) && (!r_out_vld || m_axis_tready);

    always_comb begin
        n_state = r_state;
        case (r_state)
            cfe_pkg::S_IDLE: begin
                if (in_req && (in_type == cfe_pkg::REQ_QUERY)) begin
                    n_state = cfe_pkg::S_CHECK;
                end
            end
            cfe_pkg::S_CHECK: begin
                n_state = (chk_status == cfe_pkg::STAT_OK) ? cfe_pkg::S_RUN
                                                           : cfe_pkg::S_FINISH;
            end
            cfe_pkg::S_RUN: begin
                if (r_left == '0) begin
                    n_state = cfe_pkg::S_DRAIN;
                end
            end
            cfe_pkg::S_DRAIN: begin
                // wait for the last pair to pass read, product and accumulate
                if (!r_rd_vld && !mac_busy) begin
                    n_state = cfe_pkg::S_FINISH;
                end
            end
            cfe_pkg::S_FINISH: begin
                if (out_load) begin
                    n_state = cfe_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = cfe_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= cfe_pkg::S_IDLE;
            r_rd_vld <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_rd_vld <= issue;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_req) begin
            r_pos <= in_pos;
        end
        if (r_state == cfe_pkg::S_CHECK) begin
            r_nx     <= nx;
            r_k      <= k0;
            r_j      <= '0;
            r_left   <= nf;
            r_status <= chk_status;
        end else if (issue) begin
            // walk back through the series, wrapping from the first sample to the last
            r_k    <= (r_k == '0) ? cfe_pkg::SMP_AW'(r_nx - cfe_pkg::SER_LEN_W'(1))
                                  : r_k - cfe_pkg::SMP_AW'(1);
            r_j    <= r_j + cfe_pkg::TAP_AW'(1);
            r_left <= r_left - cfe_pkg::TAP_CNT_W'(1);
        end
    end

    // ---------------------------------------------------------------
    // multiply-accumulate
    // ---------------------------------------------------------------
    assign mac_ctl.clear = (r_state == cfe_pkg::S_CHECK);
    assign mac_ctl.valid = r_rd_vld;

    cfe_mac u_mac (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_ctl    (mac_ctl),
        .i_tap    (r_tap_rd),
        .i_sample (r_smp_rd),
        .o_acc    (mac_acc),
        .o_busy   (mac_busy)
    );

    // ---------------------------------------------------------------
    // result register
    // ---------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (out_load) begin
            r_out_vld <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_out_sum    <= (r_status == cfe_pkg::STAT_OK) ? mac_acc : '0;
            r_out_status <= r_status;
        end
    end

    assign m_axis_tvalid = r_out_vld;
    assign m_axis_tdata  = cfe_pkg::OUT_TDATA_W'(r_out_sum);
    assign m_axis_tuser  = r_out_status;

`ifndef SYNTHESIS
    // a result only appears after the sequencer finishes a query
    a_load_from_finish: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(m_axis_tvalid) |-> ($past(r_state) == cfe_pkg::S_FINISH))
        else $error("result appeared without a finished query");

    // a flagged result never carries a sum
    a_flag_zero_sum: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && (m_axis_tuser != cfe_pkg::STAT_OK)) |-> (m_axis_tdata == '0))
        else $error("nonzero sum on a flagged result");

    // sample reads stay inside the series
    a_read_in_series: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        issue |-> (cfe_pkg::SER_LEN_W'(r_k) < r_nx))
        else $error("sample read outside the series");

    // read data is only in flight while a query runs or drains
    a_read_in_query: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_rd_vld |-> ((r_state == cfe_pkg::S_RUN) || (r_state == cfe_pkg::S_DRAIN)))
        else $error("store read outside a query");
`endif

endmodule

`default_nettype wire
